>>> sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, codes and header tables shared by the screen stream deframer.
// ----------------------------------------------------------------------------
package ssd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FIELDS,
    PH_PAYLOAD,
    PH_CHECK,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [1:0]  status;
    logic [7:0]  ptype;
    logic [7:0]  subd;
    logic [1:0]  fmt;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] flen;
  } res_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CORRUPT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  localparam logic [2:0] FMT_MONO    = 3'd0;
  localparam logic [2:0] FMT_DUAL    = 3'd1;
  localparam logic [2:0] FMT_PACK4   = 3'd2;
  localparam logic [2:0] FMT_RGB565  = 3'd3;
  localparam logic [2:0] FMT_UNKNOWN = 3'd4;

  localparam logic       REG_ALIGN   = 1'b0;
  localparam logic       REG_MAXLEN  = 1'b1;

  localparam logic [7:0] KIND_ACK    = 8'h06;
  localparam logic [7:0] KIND_FRAME  = 8'h0B;
  localparam logic [7:0] KIND_CHECK  = 8'h16;

  localparam logic [31:0] FCH_1RC2   = 32'h31524332;
  localparam logic [31:0] FCH_1RC3   = 32'h31524333;
  localparam logic [31:0] FCH_1RM2   = 32'h31524D32;

  function automatic logic [7:0] hdr_byte(input logic [1:0] s, input logic [2:0] j);
    logic [47:0] h;
    unique case (s)
      2'd0:    h = {8'h0B, "TYP01"};
      2'd1:    h = {8'h0B, "TYPZ1"};
      2'd2:    h = {8'h0B, "TYPZ2"};
      default: h = {8'h16, "CAL00"};
    endcase
    unique case (j)
      3'd0:    hdr_byte = h[47:40];
      3'd1:    hdr_byte = h[39:32];
      3'd2:    hdr_byte = h[31:24];
      3'd3:    hdr_byte = h[23:16];
      3'd4:    hdr_byte = h[15:8];
      default: hdr_byte = h[7:0];
    endcase
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h0;
    if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
    else if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    hex_val = t[3:0];
  endfunction

endpackage

>>> sv/ssd_fifo.sv
// ----------------------------------------------------------------------------
// ssd_fifo
// Two-entry queue; decouples the link side, the parser and the result side.
// ----------------------------------------------------------------------------
module ssd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 2'd1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

endmodule

>>> sv/ssd_parse.sv
// ----------------------------------------------------------------------------
// ssd_parse
// Byte parser: header hunt, field decode, frame judgement, payload, checksum, skip.
// ----------------------------------------------------------------------------
module ssd_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          res_space,
  input  logic          align_en,
  input  logic [31:0]   max_bytes,
  output logic          take,
  output logic          res_valid,
  output ssd_pkg::res_t res
);

  ssd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  win_r [6];
  logic [7:0]  win_nxt [6];
  logic [4:0]  fi_r, fi_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] ht_r, ht_nxt;
  logic [15:0] wd_r, wd_nxt;
  logic [2:0]  fmt_r, fmt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        derr_r, derr_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [31:0] fch_r, fch_nxt;
  logic        z2_r, z2_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] prod_r;
  logic [29:0] rowh_r;
  logic [13:0] row;

  assign row = {1'b0, wd_r[15:3]} + {13'd0, |wd_r[2:0]};

  always_ff @(posedge clk) begin
    prod_r <= 32'(wd_r) * 32'(ht_r);
    rowh_r <= 30'(row) * 30'(ht_r);
  end

  always_comb begin
    logic [7:0]  w [6];
    logic [5:0]  mk;
    logic        m;
    logic [2:0]  ksel;
    logic        found, th, judge, fin;
    logic [1:0]  fstat;
    logic [4:0]  fld, tot;
    logic [32:0] expct, fl33;
    logic [7:0]  b;
    phase_nxt = phase_r;
    for (int i = 0; i < 6; i++) win_nxt[i] = win_r[i];
    fi_nxt   = fi_r;   len_nxt = len_r;   ht_nxt  = ht_r;   wd_nxt = wd_r;
    fmt_nxt  = fmt_r;  rem_nxt = rem_r;   sum_nxt = sum_r;  pend_nxt = pend_r;
    derr_nxt = derr_r; hi_nxt  = hi_r;    fch_nxt = fch_r;  z2_nxt = z2_r;
    acc_nxt  = acc_r;
    res       = '0;
    res_valid = 1'b0;
    th = 1'b0; judge = 1'b0; fin = 1'b0; fstat = ssd_pkg::ST_OK;
    found = 1'b0; ksel = 3'd0; mk = '0; m = 1'b0;
    b = in_byte;
    fld = z2_r ? 5'd8 : 5'd6;
    tot = z2_r ? 5'd20 : 5'd18;
    expct = '0;
    fl33 = {1'b0, len_r};
    for (int i = 0; i < 6; i++) w[i] = win_r[i];
    take = in_valid & res_space;

    if (take) begin
      unique case (phase_r)
        ssd_pkg::PH_HUNT: begin
          w[fi_r[2:0]] = b;
          if (fi_r == 5'd5) begin
            fi_nxt = 5'd0;
            if (align_en) begin
              for (int k = 0; k < 6; k++) begin
                for (int s = 0; s < 4; s++) begin
                  m = 1'b1;
                  for (int j = 0; j < 6 - k; j++)
                    if (w[k+j] != ssd_pkg::hdr_byte(2'(s), 3'(j))) m = 1'b0;
                  if (m) mk[k] = 1'b1;
                end
              end
              for (int k = 5; k >= 0; k--)
                if (mk[k]) begin
                  found = 1'b1;
                  ksel = 3'(k);
                end
              if (found && ksel != 3'd0) begin
                for (int j = 0; j < 5; j++)
                  if (j + ksel < 6) w[j] = w[3'(j) + ksel];
                fi_nxt = 5'd6 - {2'b0, ksel};
              end else if (found) begin
                th = 1'b1;
              end
            end else begin
              th = 1'b1;
            end
          end else begin
            fi_nxt = fi_r + 5'd1;
          end
          for (int i = 0; i < 6; i++) win_nxt[i] = w[i];
        end
        ssd_pkg::PH_FIELDS: begin
          sum_nxt = sum_r + b;
          if (fi_r < fld) begin
            if (!ssd_pkg::is_hex(b)) pend_nxt = ssd_pkg::ST_CORRUPT;
            len_nxt = {len_r[27:0], ssd_pkg::hex_val(b)};
          end else if (fi_r < fld + 5'd8) begin
            if (!ssd_pkg::is_hex(b)) derr_nxt = 1'b1;
            if (fi_r < fld + 5'd4) ht_nxt = {ht_r[11:0], ssd_pkg::hex_val(b)};
            else wd_nxt = {wd_r[11:0], ssd_pkg::hex_val(b)};
          end else begin
            fch_nxt = {fch_r[23:0], b};
          end
          if (fi_r == tot - 5'd1) begin
            fi_nxt = 5'd0;
            if (pend_nxt != ssd_pkg::ST_OK) begin
              fin = 1'b1; fstat = ssd_pkg::ST_CORRUPT;
            end else if (derr_nxt) begin
              phase_nxt = ssd_pkg::PH_SKIP;
              rem_nxt   = fl33 + 33'd2;
              pend_nxt  = ssd_pkg::ST_CORRUPT;
            end else begin
              priority if (fch_nxt == ssd_pkg::FCH_1RC2) fmt_nxt = ssd_pkg::FMT_RGB565;
              else if (fch_nxt == ssd_pkg::FCH_1RC3) fmt_nxt = ssd_pkg::FMT_PACK4;
              else if (fch_nxt == ssd_pkg::FCH_1RM2) fmt_nxt = ssd_pkg::FMT_DUAL;
              else fmt_nxt = ssd_pkg::FMT_UNKNOWN;
              judge = 1'b1;
            end
          end else begin
            fi_nxt = fi_r + 5'd1;
          end
        end
        ssd_pkg::PH_PAYLOAD: begin
          res_valid   = 1'b1;
          res.payload = b;
          sum_nxt = sum_r + b;
          if (rem_r != '0) rem_nxt = rem_r - 33'd1;
          if (rem_nxt == '0) begin
            phase_nxt = ssd_pkg::PH_CHECK;
            fi_nxt = 5'd0;
          end
        end
        ssd_pkg::PH_CHECK: begin
          if (fi_r == 5'd0) begin
            derr_nxt = !ssd_pkg::is_hex(b);
            hi_nxt   = ssd_pkg::hex_val(b);
            fi_nxt   = 5'd1;
          end else begin
            fin = 1'b1;
            if (derr_r || !ssd_pkg::is_hex(b)) fstat = ssd_pkg::ST_CORRUPT;
            else if ({hi_r, ssd_pkg::hex_val(b)} == 8'(8'd0 - sum_r)) fstat = ssd_pkg::ST_OK;
            else fstat = ssd_pkg::ST_CORRUPT;
          end
        end
        default: begin
          if (rem_r != '0) rem_nxt = rem_r - 33'd1;
          if (rem_nxt == '0) begin
            fin = 1'b1; fstat = pend_r;
          end
        end
      endcase
    end

    if (th) begin
      sum_nxt = w[1] + w[2] + w[3] + w[4] + w[5];
      acc_nxt = 1'b0;
      fi_nxt  = 5'd0;
      if (w[0] == ssd_pkg::KIND_CHECK || w[0] == ssd_pkg::KIND_ACK) begin
        phase_nxt = ssd_pkg::PH_CHECK;
      end else if (w[0] == ssd_pkg::KIND_FRAME && w[1] == "T" && w[2] == "Y"
                   && w[3] == "P" && w[4] == "0" && w[5] == "1") begin
        wd_nxt = 16'd128; ht_nxt = 16'd64; fmt_nxt = ssd_pkg::FMT_MONO; len_nxt = 32'd1024;
        if (max_bytes < 32'd1024) begin
          phase_nxt = ssd_pkg::PH_SKIP; rem_nxt = 33'd1026; pend_nxt = ssd_pkg::ST_CAPACITY;
        end else begin
          acc_nxt = 1'b1; rem_nxt = 33'd1024; phase_nxt = ssd_pkg::PH_PAYLOAD;
        end
      end else if (w[0] == ssd_pkg::KIND_FRAME && w[1] == "T" && w[2] == "Y"
                   && w[3] == "P" && w[4] == "Z" && (w[5] == "1" || w[5] == "2")) begin
        phase_nxt = ssd_pkg::PH_FIELDS;
        z2_nxt = (w[5] != "1");
        len_nxt = '0; ht_nxt = '0; wd_nxt = '0; fch_nxt = '0;
        fmt_nxt = ssd_pkg::FMT_UNKNOWN; pend_nxt = ssd_pkg::ST_OK; derr_nxt = 1'b0;
      end else begin
        phase_nxt = ssd_pkg::PH_SKIP; rem_nxt = 33'd2; pend_nxt = ssd_pkg::ST_UNKNOWN;
      end
    end

    if (judge) begin
      unique case (fmt_nxt)
        ssd_pkg::FMT_MONO:   expct = {3'd0, rowh_r};
        ssd_pkg::FMT_DUAL:   expct = {2'd0, rowh_r, 1'b0};
        ssd_pkg::FMT_PACK4:  expct = ({1'b0, prod_r} + 33'd1) >> 1;
        default:             expct = {prod_r, 1'b0};
      endcase
      if (len_r == '0) begin
        phase_nxt = ssd_pkg::PH_SKIP; rem_nxt = 33'd2; pend_nxt = ssd_pkg::ST_UNKNOWN;
      end else if (fmt_nxt == ssd_pkg::FMT_UNKNOWN || expct != fl33) begin
        phase_nxt = ssd_pkg::PH_SKIP; rem_nxt = fl33 + 33'd2;
        pend_nxt = ssd_pkg::ST_UNKNOWN;
      end else if (len_r > max_bytes) begin
        phase_nxt = ssd_pkg::PH_SKIP; rem_nxt = fl33 + 33'd2;
        pend_nxt = ssd_pkg::ST_CAPACITY;
      end else begin
        acc_nxt = 1'b1; rem_nxt = fl33; phase_nxt = ssd_pkg::PH_PAYLOAD;
      end
    end

    if (fin) begin
      res_valid  = 1'b1;
      res.kind   = 1'b1;
      res.status = fstat;
      res.ptype  = win_r[0];
      res.subd   = win_r[5];
      if (acc_r) begin
        res.fmt    = fmt_r[1:0];
        res.width  = wd_r;
        res.height = ht_r;
        res.flen   = len_r;
      end
      phase_nxt = ssd_pkg::PH_HUNT;
      fi_nxt    = 5'd0;
      acc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ssd_pkg::PH_HUNT;
      for (int i = 0; i < 6; i++) win_r[i] <= 8'd0;
      fi_r   <= '0; len_r <= '0; ht_r <= '0; wd_r <= '0;
      fmt_r  <= ssd_pkg::FMT_UNKNOWN; rem_r <= '0; sum_r <= '0;
      pend_r <= ssd_pkg::ST_OK; derr_r <= 1'b0; hi_r <= '0; fch_r <= '0;
      z2_r   <= 1'b0; acc_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      for (int i = 0; i < 6; i++) win_r[i] <= win_nxt[i];
      fi_r   <= fi_nxt;   len_r <= len_nxt;  ht_r  <= ht_nxt;  wd_r <= wd_nxt;
      fmt_r  <= fmt_nxt;  rem_r <= rem_nxt;  sum_r <= sum_nxt;
      pend_r <= pend_nxt; derr_r <= derr_nxt; hi_r <= hi_nxt; fch_r <= fch_nxt;
      z2_r   <= z2_nxt;   acc_r <= acc_nxt;
    end
  end

endmodule

>>> sv/screen_stream_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// screen_stream_packet_deframer_top
// Screen stream packet deframer: input byte queue, parser, result queue.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         push / full           in_rx_byte
//  result    out        pop / empty           out_* fields
//  config    in         psel/penable/pwrite   paddr, pwdata, prdata
//
//  One byte per cycle sustained while the result queue has room.
//  A pushed byte is registered in the input queue, its result in the result queue.
//  Reset is synchronous; both queues come up empty, parser hunts for a header.
//  A full result queue holds the parser; the input queue then fills and raises full.
module screen_stream_packet_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        pop,
  output logic        empty,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_status,
  output logic [7:0]  out_packet_type,
  output logic [7:0]  out_packet_subtype_digit,
  output logic [1:0]  out_pix_fmt,
  output logic [15:0] out_pix_width,
  output logic [15:0] out_pix_height,
  output logic [31:0] out_data_len,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          align_r;
  logic [31:0]   maxb_r;
  logic          ib_empty, ob_full, take, res_valid;
  logic [7:0]    ib_byte;
  ssd_pkg::res_t res, ob_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ssd_pkg::REG_MAXLEN) ? maxb_r : {31'd0, align_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= 1'b1;
      maxb_r  <= 32'd262144;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ssd_pkg::REG_ALIGN) align_r <= pwdata[0];
      else maxb_r <= pwdata;
    end
  end

  ssd_fifo #(.W(8)) u_in_q (
    .clk(clk), .rst_n(rst_n), .wr(push), .wdata(in_rx_byte), .full(full),
    .rd(take), .rdata(ib_byte), .empty(ib_empty)
  );

  ssd_parse u_parse (
    .clk(clk), .rst_n(rst_n), .in_valid(~ib_empty), .in_byte(ib_byte),
    .res_space(~ob_full), .align_en(align_r), .max_bytes(maxb_r),
    .take(take), .res_valid(res_valid), .res(res)
  );

  ssd_fifo #(.W($bits(ssd_pkg::res_t))) u_out_q (
    .clk(clk), .rst_n(rst_n), .wr(res_valid), .wdata(res), .full(ob_full),
    .rd(pop), .rdata(ob_data), .empty(empty)
  );

  assign out_result_kind          = ob_data.kind;
  assign out_payload_byte         = ob_data.payload;
  assign out_status               = ob_data.status;
  assign out_packet_type          = ob_data.ptype;
  assign out_packet_subtype_digit = ob_data.subd;
  assign out_pix_fmt              = ob_data.fmt;
  assign out_pix_width            = ob_data.width;
  assign out_pix_height           = ob_data.height;
  assign out_data_len             = ob_data.flen;

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_result_kind) |-> (out_status == ssd_pkg::ST_OK
      && out_data_len == 32'd0 && out_packet_type == 8'd0))
    else $error("payload item carries header fields");

  a_end_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind) |-> (out_payload_byte == 8'd0))
    else $error("end record carries a payload byte");

  a_unaccepted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind && out_data_len == 32'd0) |->
      (out_pix_width == 16'd0 && out_pix_height == 16'd0
       && out_pix_fmt == 2'd0))
    else $error("picture fields on a frame that was not accepted");

  a_parser_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid |-> !ob_full))
    else $error("result produced with no queue space");

endmodule
